// ===== rtl/vsa_pkg.sv =====
// shared types and constants for the voice slot allocator
// no dependencies
package vsa_pkg;

  localparam int SLOTS_DEF    = 8;
  localparam int AGE_BITS_DEF = 32;
  localparam logic [3:0] LIVE_CAP_RST = 4'd5;

  typedef enum logic [1:0] {
    OP_NOTE     = 2'd0,
    OP_TICK     = 2'd1,
    OP_DONE     = 2'd2,
    OP_FADE_ALL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEAL,
    S_PICK,
    S_COUNT,
    S_DONE
  } state_t;

  // per-cycle command to the slot cells
  typedef struct packed {
    logic tick;
    logic fade_all;
    logic clear;
    logic set_fade;
    logic grant;
  } cmd_t;

endpackage

// ===== rtl/vsa_in_if.sv =====
// request channel: note, tick, finish and fade-all words
// depends on vsa_pkg
interface vsa_in_if import vsa_pkg::*; ();
  logic       valid;
  logic       ready;
  op_t        op;
  logic [2:0] slot;

  modport source(output valid, op, slot, input ready);
  modport sink(input valid, op, slot, output ready);
endinterface

// ===== rtl/vsa_out_if.sv =====
// result channel: grant, steal and live count words
// no dependencies
interface vsa_out_if;
  logic       valid;
  logic       ready;
  logic       granted_valid;
  logic [2:0] granted_slot;
  logic       stolen_valid;
  logic [2:0] stolen_slot;
  logic [3:0] live_count;

  modport source(output valid, granted_valid, granted_slot, stolen_valid, stolen_slot,
                 live_count, input ready);
  modport sink(input valid, granted_valid, granted_slot, stolen_valid, stolen_slot,
               live_count, output ready);
endinterface

// ===== rtl/vsa_cell.sv =====
// one voice slot: active, fading and age state plus one registered stage
// of the search chain; depends on vsa_pkg
module vsa_cell import vsa_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF,
  parameter int INDEX    = 0,
  parameter int IDX_W    = $clog2(SLOTS),
  parameter int CNT_W    = $clog2(SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [IDX_W-1:0]    tgt,
  input  logic [CNT_W-1:0]    cnt_i,
  input  logic                lv_f_i,
  input  logic [IDX_W-1:0]    lv_i_i,
  input  logic [AGE_BITS-1:0] lv_a_i,
  input  logic                fr_f_i,
  input  logic [IDX_W-1:0]    fr_i_i,
  input  logic                fd_f_i,
  input  logic [IDX_W-1:0]    fd_i_i,
  input  logic [AGE_BITS-1:0] fd_a_i,
  input  logic                ac_f_i,
  input  logic [IDX_W-1:0]    ac_i_i,
  input  logic [AGE_BITS-1:0] ac_a_i,
  output logic [CNT_W-1:0]    cnt_o,
  output logic                lv_f_o,
  output logic [IDX_W-1:0]    lv_i_o,
  output logic [AGE_BITS-1:0] lv_a_o,
  output logic                fr_f_o,
  output logic [IDX_W-1:0]    fr_i_o,
  output logic                fd_f_o,
  output logic [IDX_W-1:0]    fd_i_o,
  output logic [AGE_BITS-1:0] fd_a_o,
  output logic                ac_f_o,
  output logic [IDX_W-1:0]    ac_i_o,
  output logic [AGE_BITS-1:0] ac_a_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                active;
  logic                fading;
  logic [AGE_BITS-1:0] age;
  logic                hit;
  logic                live;

  assign hit  = (tgt == MY_IDX);
  assign live = active && !fading;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      fading <= 1'b0;
      age    <= '0;
    end else if (cmd.tick) begin
      if (active && (age != '1)) begin
        age <= age + AGE_BITS'(1);
      end
    end else if (cmd.fade_all) begin
      fading <= 1'b1;
    end else if (cmd.clear && hit) begin
      active <= 1'b0;
      fading <= 1'b0;
      age    <= '0;
    end else if (cmd.set_fade && hit) begin
      fading <= 1'b1;
    end else if (cmd.grant && hit) begin
      active <= 1'b1;
      fading <= 1'b0;
      age    <= '0;
    end
  end

  // search stage, lowest index wins ties
  always_ff @(posedge clk) begin
    cnt_o <= cnt_i + CNT_W'(live);
    if (live && (!lv_f_i || (age > lv_a_i))) begin
      lv_f_o <= 1'b1;
      lv_i_o <= MY_IDX;
      lv_a_o <= age;
    end else begin
      lv_f_o <= lv_f_i;
      lv_i_o <= lv_i_i;
      lv_a_o <= lv_a_i;
    end
    if (!fr_f_i && !active) begin
      fr_f_o <= 1'b1;
      fr_i_o <= MY_IDX;
    end else begin
      fr_f_o <= fr_f_i;
      fr_i_o <= fr_i_i;
    end
    if (fading && (!fd_f_i || (age > fd_a_i))) begin
      fd_f_o <= 1'b1;
      fd_i_o <= MY_IDX;
      fd_a_o <= age;
    end else begin
      fd_f_o <= fd_f_i;
      fd_i_o <= fd_i_i;
      fd_a_o <= fd_a_i;
    end
    if (active && (!ac_f_i || (age > ac_a_i))) begin
      ac_f_o <= 1'b1;
      ac_i_o <= MY_IDX;
      ac_a_o <= age;
    end else begin
      ac_f_o <= ac_f_i;
      ac_i_o <= ac_i_i;
      ac_a_o <= ac_a_i;
    end
  end

endmodule

// ===== rtl/vsa_ctrl.sv =====
// sequencer: handshakes, cap register, scan phases over the cell chain
// and the result register; depends on vsa_pkg, vsa_in_if, vsa_out_if
module vsa_ctrl import vsa_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX_W = $clog2(SLOTS),
  parameter int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  vsa_in_if.sink           req,
  vsa_out_if.source        rsp,
  input  logic             cfg_wr_en,
  input  logic [3:0]       cfg_wr_data,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] tgt,
  input  logic [CNT_W-1:0] tail_cnt,
  input  logic             tail_lv_f,
  input  logic [IDX_W-1:0] tail_lv_i,
  input  logic             tail_fr_f,
  input  logic [IDX_W-1:0] tail_fr_i,
  input  logic             tail_fd_f,
  input  logic [IDX_W-1:0] tail_fd_i,
  input  logic             tail_ac_f,
  input  logic [IDX_W-1:0] tail_ac_i
);

  localparam int PH_W = $clog2(SLOTS + 1);
  localparam logic [PH_W-1:0] PH_END = PH_W'(SLOTS);

  state_t           state, state_next;
  logic [PH_W-1:0]  ph, ph_next;
  logic [3:0]       live_cap;
  logic             gv, gv_next, sv, sv_next;
  logic [IDX_W-1:0] gs, gs_next, ss, ss_next;
  logic [CNT_W-1:0] res_cnt, res_cnt_next;
  logic             load;
  logic             cap_hit;
  logic             slot_ok;
  logic [IDX_W-1:0] pick;
  logic [IDX_W+2:0] slot_ext;
  logic [IDX_W+2:0] gs_ext, ss_ext;
  logic [CNT_W+3:0] cnt_ext;

  assign slot_ext = (IDX_W + 3)'(req.slot);
  assign slot_ok  = (32'(req.slot) < SLOTS);
  assign cap_hit  = ((CNT_W + 4)'(tail_cnt) >= (CNT_W + 4)'(live_cap));
  assign gs_ext   = (IDX_W + 3)'(gs);
  assign ss_ext   = (IDX_W + 3)'(ss);
  assign cnt_ext  = (CNT_W + 4)'(res_cnt);

  always_comb begin
    if (tail_fr_f) begin
      pick = tail_fr_i;
    end else if (tail_fd_f) begin
      pick = tail_fd_i;
    end else if (tail_ac_f) begin
      pick = tail_ac_i;
    end else begin
      pick = '0;
    end
  end

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    ph_next      = ph + PH_W'(1);
    gv_next      = gv;
    gs_next      = gs;
    sv_next      = sv;
    ss_next      = ss;
    res_cnt_next = res_cnt;
    cmd          = '0;
    tgt          = slot_ext[IDX_W-1:0];
    load         = 1'b0;
    case (state)
      S_IDLE: begin
        ph_next = '0;
        if (req.valid) begin
          gv_next = 1'b0;
          gs_next = '0;
          sv_next = 1'b0;
          ss_next = '0;
          case (req.op)
            OP_NOTE: state_next = S_STEAL;
            OP_TICK: begin
              cmd.tick   = 1'b1;
              state_next = S_COUNT;
            end
            OP_DONE: begin
              cmd.clear  = slot_ok;
              state_next = S_COUNT;
            end
            default: begin
              cmd.fade_all = 1'b1;
              state_next   = S_COUNT;
            end
          endcase
        end
      end
      S_STEAL: begin
        if (ph == PH_END) begin
          ph_next = '0;
          tgt     = tail_lv_i;
          if (cap_hit && tail_lv_f) begin
            cmd.set_fade = 1'b1;
            sv_next      = 1'b1;
            ss_next      = tail_lv_i;
          end
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (ph == PH_END) begin
          ph_next    = '0;
          tgt        = pick;
          cmd.grant  = 1'b1;
          gv_next    = 1'b1;
          gs_next    = pick;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        if (ph == PH_END) begin
          ph_next      = '0;
          res_cnt_next = tail_cnt;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        ph_next = '0;
        if (!rsp.valid || rsp.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= '0;
      live_cap  <= LIVE_CAP_RST;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      if (cfg_wr_en) begin
        live_cap <= cfg_wr_data;
      end
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    gv      <= gv_next;
    gs      <= gs_next;
    sv      <= sv_next;
    ss      <= ss_next;
    res_cnt <= res_cnt_next;
    if (load) begin
      rsp.granted_valid <= gv;
      rsp.granted_slot  <= gs_ext[2:0];
      rsp.stolen_valid  <= sv;
      rsp.stolen_slot   <= ss_ext[2:0];
      rsp.live_count    <= cnt_ext[3:0];
    end
  end

endmodule

// ===== rtl/voice_slot_allocator.sv =====
// voice slot allocator: row of slot cells with a registered search chain
// tick, finish and fade-all words run one count scan of the chain; note words run
// a steal scan, a pick scan and a count scan; one word at a time, and a new word is
// taken only after the result of the last one is loaded into the result register
// synchronous reset clears every slot and loads the cap with 5
module voice_slot_allocator import vsa_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  vsa_in_if.sink     req,
  vsa_out_if.source  rsp,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  cmd_t             cmd;
  logic [IDX_W-1:0] tgt;

  logic [CNT_W-1:0]    c_cnt  [SLOTS+1];
  logic                c_lv_f [SLOTS+1];
  logic [IDX_W-1:0]    c_lv_i [SLOTS+1];
  logic [AGE_BITS-1:0] c_lv_a [SLOTS+1];
  logic                c_fr_f [SLOTS+1];
  logic [IDX_W-1:0]    c_fr_i [SLOTS+1];
  logic                c_fd_f [SLOTS+1];
  logic [IDX_W-1:0]    c_fd_i [SLOTS+1];
  logic [AGE_BITS-1:0] c_fd_a [SLOTS+1];
  logic                c_ac_f [SLOTS+1];
  logic [IDX_W-1:0]    c_ac_i [SLOTS+1];
  logic [AGE_BITS-1:0] c_ac_a [SLOTS+1];

  // empty search word into the head of the chain
  assign c_cnt[0]  = '0;
  assign c_lv_f[0] = 1'b0;
  assign c_lv_i[0] = '0;
  assign c_lv_a[0] = '0;
  assign c_fr_f[0] = 1'b0;
  assign c_fr_i[0] = '0;
  assign c_fd_f[0] = 1'b0;
  assign c_fd_i[0] = '0;
  assign c_fd_a[0] = '0;
  assign c_ac_f[0] = 1'b0;
  assign c_ac_i[0] = '0;
  assign c_ac_a[0] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    vsa_cell #(
      .SLOTS   (SLOTS),
      .AGE_BITS(AGE_BITS),
      .INDEX   (k),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .tgt   (tgt),
      .cnt_i (c_cnt[k]),
      .lv_f_i(c_lv_f[k]),
      .lv_i_i(c_lv_i[k]),
      .lv_a_i(c_lv_a[k]),
      .fr_f_i(c_fr_f[k]),
      .fr_i_i(c_fr_i[k]),
      .fd_f_i(c_fd_f[k]),
      .fd_i_i(c_fd_i[k]),
      .fd_a_i(c_fd_a[k]),
      .ac_f_i(c_ac_f[k]),
      .ac_i_i(c_ac_i[k]),
      .ac_a_i(c_ac_a[k]),
      .cnt_o (c_cnt[k+1]),
      .lv_f_o(c_lv_f[k+1]),
      .lv_i_o(c_lv_i[k+1]),
      .lv_a_o(c_lv_a[k+1]),
      .fr_f_o(c_fr_f[k+1]),
      .fr_i_o(c_fr_i[k+1]),
      .fd_f_o(c_fd_f[k+1]),
      .fd_i_o(c_fd_i[k+1]),
      .fd_a_o(c_fd_a[k+1]),
      .ac_f_o(c_ac_f[k+1]),
      .ac_i_o(c_ac_i[k+1]),
      .ac_a_o(c_ac_a[k+1])
    );
  end

  vsa_ctrl #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .tgt        (tgt),
    .tail_cnt   (c_cnt[SLOTS]),
    .tail_lv_f  (c_lv_f[SLOTS]),
    .tail_lv_i  (c_lv_i[SLOTS]),
    .tail_fr_f  (c_fr_f[SLOTS]),
    .tail_fr_i  (c_fr_i[SLOTS]),
    .tail_fd_f  (c_fd_f[SLOTS]),
    .tail_fd_i  (c_fd_i[SLOTS]),
    .tail_ac_f  (c_ac_f[SLOTS]),
    .tail_ac_i  (c_ac_i[SLOTS])
  );

endmodule
